// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL of the vector clock core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check an implication property on the rising clock edge outside reset.
`define VCU_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// Check that a condition never holds on the rising clock edge outside reset.
`define VCU_NEVER(lbl, clk_s, rstn_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) else $error(msg);

`else

`define VCU_ASSERT(lbl, clk_s, rstn_s, prop, msg)
`define VCU_NEVER(lbl, clk_s, rstn_s, cond, msg)

`endif

`endif

// ===== rtl/core/vcu_pkg.sv =====
`default_nettype none

package vcu_pkg;

  // Fixed field widths of the word ports
  localparam int THREAD_W   = 6;
  localparam int COUNT_IN_W = 31;
  localparam int READ_W     = 32;

  // Read results: saturation limit and the absent marker (-1)
  localparam logic [READ_W-1:0] READ_MAX    = 32'h7FFF_FFFF;
  localparam logic [READ_W-1:0] READ_ABSENT = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    MODE_CLEAR = 3'd0,
    MODE_SET   = 3'd1,
    MODE_INC   = 3'd2,
    MODE_JOIN  = 3'd3,
    MODE_CMP   = 3'd4,
    MODE_READ  = 3'd5
  } mode_t;

  // Control of the word held in the update stage
  typedef struct packed {
    mode_t mode;
    logic  in_range;
    logic  last;
  } s1_ctl_t;

  // One result word
  typedef struct packed {
    logic [READ_W-1:0] read_value;
    logic              entry_present;
    logic              compare_done;
    logic              clocks_equal;
    logic              stored_before;
    logic              stored_after;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/vector_clock_unit_core.sv =====
// Vector clock core: holds one sparse vector clock of up to MAX_THREADS
// threads, each with a saturating COUNT_BITS-bit counter in a synchronous
// memory, and a presence mask in flops. Each input word clears, sets,
// increments, reads, joins one element of another clock, or compares one
// element of another clock; every word gives exactly one result word.
// A word passes from acceptance through the counter memory read, then
// the update and write back, into the output register. The block sustains
// one word per cycle while the result side takes its words; a write
// followed at once by a word to the same thread is served by a one-entry
// forward register instead of the memory. Counters need no clearing pass
// after reset, so words are taken from the first cycle after reset.
`default_nettype none
`include "assert_macros.svh"

module vector_clock_unit_core #(
  parameter int MAX_THREADS = 64,
  parameter int COUNT_BITS  = 31
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [2:0]                     in_mode,
  input  wire logic [vcu_pkg::THREAD_W-1:0]   in_entry_thread,
  input  wire logic [vcu_pkg::COUNT_IN_W-1:0] in_entry_count,
  input  wire logic                           in_last_element,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [vcu_pkg::READ_W-1:0]   out_read_value,
  output logic                                out_entry_present,
  output logic                                out_compare_done,
  output logic                                out_clocks_equal,
  output logic                                out_stored_before,
  output logic                                out_stored_after
);

  import vcu_pkg::*;

  localparam int TIDX_W = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int VWIDE  = (COUNT_BITS > COUNT_IN_W) ? COUNT_BITS : COUNT_IN_W;

  logic                  in_fire;
  logic                  s1_fire;
  logic                  s1_valid_r, s1_valid_nxt;
  s1_ctl_t               s1_ctl_r;
  logic [TIDX_W-1:0]     s1_tid_r;
  logic [COUNT_BITS-1:0] s1_val_r;
  logic                  out_valid_r, out_valid_nxt;
  result_t               out_res_r;
  result_t               res;
  logic [COUNT_BITS-1:0] rd_data;
  logic                  wr_en;
  logic [TIDX_W-1:0]     wr_addr;
  logic [COUNT_BITS-1:0] wr_data;
  logic [VWIDE-1:0]      val_wide;
  logic                  in_range;

  // Handshake: stage one drains into the output register when it is free
  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_valid && in_ready;

  assign val_wide = VWIDE'(in_entry_count);
  assign in_range = {1'b0, in_entry_thread} < (THREAD_W + 1)'(MAX_THREADS);

  // Advance stage valid and output valid
  always_comb begin
    s1_valid_nxt  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the accepted word while its counter is read
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ctl_r.mode     <= mode_t'(in_mode);
      s1_ctl_r.in_range <= in_range;
      s1_ctl_r.last     <= in_last_element;
      s1_tid_r          <= in_entry_thread[TIDX_W-1:0];
      s1_val_r          <= val_wide[COUNT_BITS-1:0];
    end
  end

  // Hold the result word until it is taken
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res_r <= res;
    end
  end

  vcu_cnt_ram #(
    .DEPTH (MAX_THREADS),
    .AW    (TIDX_W),
    .DW    (COUNT_BITS)
  ) u_cnt_ram (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (in_entry_thread[TIDX_W-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  vcu_update #(
    .MAX_THREADS (MAX_THREADS),
    .COUNT_BITS  (COUNT_BITS),
    .TIDX_W      (TIDX_W)
  ) u_update (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (s1_fire),
    .ctl     (s1_ctl_r),
    .tid     (s1_tid_r),
    .val     (s1_val_r),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .res     (res)
  );

  assign out_valid         = out_valid_r;
  assign out_read_value    = $signed(out_res_r.read_value);
  assign out_entry_present = out_res_r.entry_present;
  assign out_compare_done  = out_res_r.compare_done;
  assign out_clocks_equal  = out_res_r.clocks_equal;
  assign out_stored_before = out_res_r.stored_before;
  assign out_stored_after  = out_res_r.stored_after;

  `VCU_ASSERT(a_s1_holds, clk, rst_n, (s1_valid_r && !s1_fire) |=> (s1_valid_r && $stable(s1_tid_r) && $stable(s1_val_r)), "stalled word changed")
  `VCU_ASSERT(a_out_loads, clk, rst_n, !out_valid_r |=> (out_valid_r == $past(s1_valid_r)), "output register load mismatch")
  `VCU_ASSERT(a_write_on_fire, clk, rst_n, wr_en |-> (s1_valid_r && (!out_valid_r || out_ready)), "counter written outside a finished word")

endmodule

`default_nettype wire

// ===== rtl/core/vcu_cnt_ram.sv =====
`default_nettype none

module vcu_cnt_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 31
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  // Read old data on a same-address write; the forward path covers it
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/vcu_update.sv =====
`default_nettype none
`include "assert_macros.svh"

module vcu_update #(
  parameter int MAX_THREADS = 64,
  parameter int COUNT_BITS  = 31,
  parameter int TIDX_W      = 6
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  fire,
  input  wire vcu_pkg::s1_ctl_t      ctl,
  input  wire logic [TIDX_W-1:0]     tid,
  input  wire logic [COUNT_BITS-1:0] val,
  input  wire logic [COUNT_BITS-1:0] rd_data,
  output logic                       wr_en,
  output logic      [TIDX_W-1:0]     wr_addr,
  output logic      [COUNT_BITS-1:0] wr_data,
  output vcu_pkg::result_t           res
);

  import vcu_pkg::*;

  localparam int WIDE = (COUNT_BITS > READ_W) ? COUNT_BITS : READ_W;

  logic [MAX_THREADS-1:0] mask_r, mask_nxt;
  logic [MAX_THREADS-1:0] oacc_r, oacc_nxt;
  logic                   gt_r, gt_nxt;
  logic                   sm_r, sm_nxt;
  logic                   fwd_v_r;
  logic [TIDX_W-1:0]      fwd_addr_r;
  logic [COUNT_BITS-1:0]  fwd_data_r;

  logic [MAX_THREADS-1:0] bit_sel;
  logic                   here;
  logic [COUNT_BITS-1:0]  cur;
  logic [WIDE-1:0]        cur_wide;
  logic                   we;
  logic [COUNT_BITS-1:0]  wdata;
  logic                   eq, shared;

  // Select the thread bit and the current counter, forwarding the last write
  assign bit_sel  = ctl.in_range ? (MAX_THREADS'(1) << tid) : '0;
  assign here     = |(mask_r & bit_sel);
  assign cur      = (fwd_v_r && (fwd_addr_r == tid)) ? fwd_data_r : rd_data;
  assign cur_wide = WIDE'(cur);

  // Compute the state update and the result word
  always_comb begin
    mask_nxt = mask_r;
    oacc_nxt = oacc_r;
    gt_nxt   = gt_r;
    sm_nxt   = sm_r;
    we       = 1'b0;
    wdata    = val;
    eq       = 1'b0;
    shared   = 1'b0;
    res      = '0;
    unique case (ctl.mode)
      MODE_CLEAR: begin
        mask_nxt = '0;
        oacc_nxt = '0;
        gt_nxt   = 1'b0;
        sm_nxt   = 1'b0;
      end
      MODE_SET: begin
        if (ctl.in_range) begin
          we       = 1'b1;
          mask_nxt = mask_r | bit_sel;
        end
      end
      MODE_INC: begin
        if (here && (cur != '1)) begin
          we    = 1'b1;
          wdata = cur + COUNT_BITS'(1);
        end
      end
      MODE_JOIN: begin
        if (ctl.in_range) begin
          we       = !here || (val > cur);
          mask_nxt = mask_r | bit_sel;
        end
      end
      MODE_CMP: begin
        if (ctl.in_range) begin
          oacc_nxt = oacc_r | bit_sel;
          if (here) begin
            gt_nxt = gt_r || (cur > val);
            sm_nxt = sm_r || (cur < val);
          end
        end
        if (ctl.last) begin
          eq     = (mask_r == oacc_nxt) && !gt_nxt && !sm_nxt;
          shared = |(mask_r & oacc_nxt);
          res.compare_done  = 1'b1;
          res.clocks_equal  = eq;
          res.stored_before = !eq && shared && ((mask_r & ~oacc_nxt) == '0) && !gt_nxt;
          res.stored_after  = !eq && shared && ((oacc_nxt & ~mask_r) == '0) && !sm_nxt;
          oacc_nxt = '0;
          gt_nxt   = 1'b0;
          sm_nxt   = 1'b0;
        end
      end
      MODE_READ: begin
        if (!here) begin
          res.read_value = READ_ABSENT;
        end else if (cur_wide > WIDE'(READ_MAX)) begin
          res.read_value = READ_MAX;
        end else begin
          res.read_value = cur_wide[READ_W-1:0];
        end
      end
      default: begin
      end
    endcase
    res.entry_present = |(mask_nxt & bit_sel);
  end

  assign wr_en   = fire && we;
  assign wr_addr = tid;
  assign wr_data = wdata;

  // Advance mask and compare accumulators on each finished word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r  <= '0;
      oacc_r  <= '0;
      gt_r    <= 1'b0;
      sm_r    <= 1'b0;
      fwd_v_r <= 1'b0;
    end else if (fire) begin
      mask_r  <= mask_nxt;
      oacc_r  <= oacc_nxt;
      gt_r    <= gt_nxt;
      sm_r    <= sm_nxt;
      fwd_v_r <= we;
    end
  end

  // Hold the last written counter for the word whose read overlapped it
  always_ff @(posedge clk) begin
    if (fire && we) begin
      fwd_addr_r <= tid;
      fwd_data_r <= wdata;
    end
  end

  `VCU_ASSERT(a_verdict_onehot, clk, rst_n, res.compare_done |-> $onehot0({res.clocks_equal, res.stored_before, res.stored_after}), "compare verdicts overlap")
  `VCU_ASSERT(a_cmp_acc_cleared, clk, rst_n, (fire && ctl.mode == MODE_CMP && ctl.last) |=> (oacc_r == '0 && !gt_r && !sm_r), "compare accumulators not cleared")
  `VCU_ASSERT(a_clear_empties, clk, rst_n, (fire && ctl.mode == MODE_CLEAR) |=> (mask_r == '0), "clear left threads present")

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
module tb_top;
  import vcu_pkg::*;

  localparam int NUM_THREADS  = 64;
  localparam int NUM_ITEMS    = 1000;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [COUNT_IN_W-1:0] CNT_TOP = {COUNT_IN_W{1'b1}};

  typedef struct {
    mode_t                 op;
    logic [THREAD_W-1:0]   tid;
    logic [COUNT_IN_W-1:0] cnt;
    logic                  last;
    bit                    typed;
    result_t               want;
  } stim_row_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [2:0]                    in_mode = MODE_CLEAR;
  logic [THREAD_W-1:0]           in_entry_thread = '0;
  logic [COUNT_IN_W-1:0]         in_entry_count = '0;
  logic                          in_last_element = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [READ_W-1:0]      out_read_value;
  logic                          out_entry_present;
  logic                          out_compare_done;
  logic                          out_clocks_equal;
  logic                          out_stored_before;
  logic                          out_stored_after;

  // Shadow copy of the stored vector clock and the compare accumulators
  logic [COUNT_IN_W-1:0] vc_count [NUM_THREADS];
  logic [NUM_THREADS-1:0] vc_mask = '0;
  logic [NUM_THREADS-1:0] cmp_mask = '0;
  logic                   cmp_greater = 1'b0;
  logic                   cmp_smaller = 1'b0;

  result_t               expected_q [$];
  stim_row_t             directed_q [$];
  logic [THREAD_W-1:0]   strm_tid [$];
  logic [COUNT_IN_W-1:0] strm_cnt [$];
  int                    idle_run [2] = '{0, 0};
  int                    fail_count = 0;
  int                    sent_words = 0;
  int                    idle_cycles = 0;

  vector_clock_unit_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_entry_thread   (in_entry_thread),
    .in_entry_count    (in_entry_count),
    .in_last_element   (in_last_element),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_read_value    (out_read_value),
    .out_entry_present (out_entry_present),
    .out_compare_done  (out_compare_done),
    .out_clocks_equal  (out_clocks_equal),
    .out_stored_before (out_stored_before),
    .out_stored_after  (out_stored_after)
  );

  always #6 clk = ~clk;

  // Apply one word to the shadow clock and return the result it gives
  function automatic result_t vclock_step(mode_t op, logic [THREAD_W-1:0] tid,
                                          logic [COUNT_IN_W-1:0] cnt, logic last);
    result_t                r;
    logic [NUM_THREADS-1:0] sel;
    logic                   here;
    logic                   same;
    logic                   shared;
    r = '0;
    sel = {{(NUM_THREADS-1){1'b0}}, 1'b1} << tid;
    here = |(vc_mask & sel);
    case (op)
      MODE_CLEAR: begin
        vc_mask = '0;
        cmp_mask = '0;
        cmp_greater = 1'b0;
        cmp_smaller = 1'b0;
      end
      MODE_SET: begin
        vc_count[tid] = cnt;
        vc_mask |= sel;
      end
      MODE_INC: begin
        if (here && vc_count[tid] != CNT_TOP) vc_count[tid] = vc_count[tid] + 1'b1;
      end
      MODE_JOIN: begin
        if (!here || cnt > vc_count[tid]) vc_count[tid] = cnt;
        vc_mask |= sel;
      end
      MODE_CMP: begin
        cmp_mask |= sel;
        if (here) begin
          if (vc_count[tid] > cnt) cmp_greater = 1'b1;
          if (vc_count[tid] < cnt) cmp_smaller = 1'b1;
        end
        // Verdicts on the final element, then reset the accumulators
        if (last) begin
          same = (vc_mask == cmp_mask) && !cmp_greater && !cmp_smaller;
          shared = |(vc_mask & cmp_mask);
          r.compare_done = 1'b1;
          r.clocks_equal = same;
          r.stored_before = !same && shared && ((vc_mask & ~cmp_mask) == '0) && !cmp_greater;
          r.stored_after = !same && shared && ((cmp_mask & ~vc_mask) == '0) && !cmp_smaller;
          cmp_mask = '0;
          cmp_greater = 1'b0;
          cmp_smaller = 1'b0;
        end
      end
      MODE_READ: begin
        r.read_value = here ? READ_W'(vc_count[tid]) : READ_ABSENT;
      end
      default: ;
    endcase
    r.entry_present = |(vc_mask & sel);
    return r;
  endfunction

  // Wait before the next word: random, with occasional runs of no wait
  function automatic int draw_wait(int side);
    if (idle_run[side] > 0) begin
      idle_run[side]--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      idle_run[side] = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 10);
  endfunction

  function automatic logic [THREAD_W-1:0] pick_thread();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 8) return THREAD_W'($urandom_range(0, 7));
    if (roll == 8) return THREAD_W'($urandom_range(56, 63));
    return THREAD_W'($urandom_range(0, NUM_THREADS - 1));
  endfunction

  function automatic logic [COUNT_IN_W-1:0] pick_count();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 12) return COUNT_IN_W'($urandom_range(0, 15));
    if (roll < 15) return CNT_TOP - COUNT_IN_W'($urandom_range(0, 3));
    return COUNT_IN_W'($urandom());
  endfunction

  function automatic void add_row(mode_t op, logic [THREAD_W-1:0] tid,
                                  logic [COUNT_IN_W-1:0] cnt, logic last);
    stim_row_t row;
    row.op = op;
    row.tid = tid;
    row.cnt = cnt;
    row.last = last;
    row.typed = 1'b0;
    row.want = '0;
    directed_q.insert(directed_q.size(), row);
  endfunction

  function automatic void add_known(mode_t op, logic [THREAD_W-1:0] tid,
                                    logic [COUNT_IN_W-1:0] cnt, logic last,
                                    logic [READ_W-1:0] rd, logic pres, logic done,
                                    logic eq, logic bef, logic aft);
    stim_row_t row;
    row.op = op;
    row.tid = tid;
    row.cnt = cnt;
    row.last = last;
    row.typed = 1'b1;
    row.want.read_value = rd;
    row.want.entry_present = pres;
    row.want.compare_done = done;
    row.want.clocks_equal = eq;
    row.want.stored_before = bef;
    row.want.stored_after = aft;
    directed_q.insert(directed_q.size(), row);
  endfunction

  function automatic void field_check(string name, logic [READ_W-1:0] want,
                                      logic [READ_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Drive one word, hold it until taken, then record its expected result
  task automatic send_word(mode_t op, logic [THREAD_W-1:0] tid,
                           logic [COUNT_IN_W-1:0] cnt, logic last,
                           bit typed, result_t want);
    int      gap;
    result_t pred;
    gap = draw_wait(0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= op;
    in_entry_thread <= tid;
    in_entry_count <= cnt;
    in_last_element <= last;
    do @(posedge clk); while (!in_ready);
    pred = vclock_step(op, tid, cnt, last);
    expected_q.insert(expected_q.size(), typed ? want : pred);
    sent_words++;
  endtask

  // Send the queued stream of another clock, last flag on its final element
  task automatic send_stream(mode_t op);
    int n;
    n = strm_tid.size();
    for (int i = 0; i < n; i++)
      send_word(op, strm_tid[i], strm_cnt[i], (i == n - 1), 1'b0, '0);
  endtask

  // Stimulus
  initial begin
    int                    kind;
    int                    len;
    int                    variant;
    int                    k;
    logic [THREAD_W-1:0]   t;
    stim_row_t             row;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words: extremes, every mode, the corner cases
    add_known(MODE_READ,  6'd0,  31'd0,   1'b0, READ_ABSENT,
              1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    add_known(MODE_SET,   6'd63, CNT_TOP, 1'b0, '0,
              1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
    add_known(MODE_READ,  6'd63, 31'd0,   1'b0, READ_MAX,
              1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
    // increment at the counter maximum holds
    add_known(MODE_INC,   6'd63, 31'd0,   1'b0, '0,
              1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
    add_known(MODE_READ,  6'd63, 31'd0,   1'b0, READ_MAX,
              1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
    // increment on an absent thread is dropped
    add_known(MODE_INC,   6'd5,  31'd0,   1'b0, '0,
              1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    add_known(MODE_SET,   6'd0,  31'd0,   1'b0, '0,
              1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
    add_row(MODE_INC,  6'd0,  31'd0, 1'b0);
    add_row(MODE_READ, 6'd0,  31'd0, 1'b0);
    // overwrite a present entry, then join below and above it
    add_row(MODE_SET,  6'd0,  31'd7, 1'b0);
    add_row(MODE_JOIN, 6'd0,  31'd3, 1'b0);
    add_row(MODE_JOIN, 6'd0,  31'd9, 1'b0);
    add_row(MODE_JOIN, 6'd10, 31'h5555_5555, 1'b0);
    add_row(MODE_READ, 6'd0,  31'd0, 1'b0);
    // compare against an identical clock
    add_row(MODE_CMP,  6'd0,  31'd9, 1'b0);
    add_row(MODE_CMP,  6'd10, 31'h5555_5555, 1'b0);
    add_known(MODE_CMP, 6'd63, CNT_TOP, 1'b1, '0,
              1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
    add_row(MODE_CMP,  6'd0,  31'd10, 1'b1);
    add_known(MODE_CLEAR, 6'd0, 31'd0, 1'b0, '0,
              1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    // compare with an empty stored clock
    add_row(MODE_CMP,  6'd0,  31'd0, 1'b1);
    // stored clock strictly before the streamed one
    add_row(MODE_SET,  6'd1,  31'd4, 1'b0);
    add_row(MODE_CMP,  6'd1,  31'd5, 1'b0);
    add_row(MODE_CMP,  6'd2,  31'h2AAA_AAAA, 1'b1);
    // repeated thread within a join stream
    add_row(MODE_JOIN, 6'd1,  31'd2, 1'b0);
    add_row(MODE_JOIN, 6'd1,  31'd8, 1'b0);
    add_row(MODE_READ, 6'd1,  31'd0, 1'b0);

    foreach (directed_q[i]) begin
      row = directed_q[i];
      send_word(row.op, row.tid, row.cnt, row.last, row.typed, row.want);
    end

    // Random words: clears, sets, increments, reads, and join and compare streams
    while (sent_words < NUM_ITEMS) begin
      kind = $urandom_range(0, 99);
      strm_tid.delete();
      strm_cnt.delete();
      if (kind < 8) begin
        send_word(MODE_CLEAR, THREAD_W'($urandom()), COUNT_IN_W'($urandom()),
                  1'($urandom()), 1'b0, '0);
      end else if (kind < 28) begin
        send_word(MODE_SET, pick_thread(), pick_count(), 1'($urandom()), 1'b0, '0);
      end else if (kind < 38) begin
        send_word(MODE_INC, pick_thread(), COUNT_IN_W'($urandom()), 1'($urandom()),
                  1'b0, '0);
      end else if (kind < 52) begin
        send_word(MODE_READ, pick_thread(), COUNT_IN_W'($urandom()), 1'($urandom()),
                  1'b0, '0);
      end else if (kind < 70) begin
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++) begin
          t = ($urandom_range(0, 4) == 0 && i > 0) ? strm_tid[i-1] : pick_thread();
          strm_tid.insert(strm_tid.size(), t);
          strm_cnt.insert(strm_cnt.size(), pick_count());
        end
        send_stream(MODE_JOIN);
      end else begin
        // Mirror a small stored clock and nudge it toward a chosen verdict, else send a random stream
        if (kind < 92 && $countones(vc_mask) <= 12) begin
          for (int i = 0; i < NUM_THREADS; i++)
            if (vc_mask[i]) begin
              strm_tid.insert(strm_tid.size(), THREAD_W'(i));
              strm_cnt.insert(strm_cnt.size(), vc_count[i]);
            end
          variant = $urandom_range(0, 4);
          if (strm_tid.size() > 0) begin
            k = $urandom_range(0, strm_tid.size() - 1);
            case (variant)
              1: strm_cnt[k] = strm_cnt[k] + 1'b1;
              2: strm_cnt[k] = strm_cnt[k] - 1'b1;
              3: begin
                strm_tid.delete(k);
                strm_cnt.delete(k);
              end
              4: begin
                strm_tid.insert(strm_tid.size(), pick_thread());
                strm_cnt.insert(strm_cnt.size(), pick_count());
              end
              default: ;
            endcase
          end
        end else begin
          len = $urandom_range(1, 6);
          for (int i = 0; i < len; i++) begin
            strm_tid.insert(strm_tid.size(), pick_thread());
            strm_cnt.insert(strm_cnt.size(), pick_count());
          end
        end
        if (strm_tid.size() == 0) begin
          strm_tid.insert(strm_tid.size(), pick_thread());
          strm_cnt.insert(strm_cnt.size(), pick_count());
        end
        send_stream(MODE_CMP);
      end
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then watch for strays
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Result side: stall at random, check each word taken
  initial begin
    int      stall;
    result_t want;
    wait (rst_n === 1'b1);
    forever begin
      stall = draw_wait(1);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual read_value %h",
                 $time, out_read_value);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        field_check("read_value", want.read_value, out_read_value);
        field_check("entry_present", READ_W'(want.entry_present), READ_W'(out_entry_present));
        field_check("compare_done", READ_W'(want.compare_done), READ_W'(out_compare_done));
        field_check("clocks_equal", READ_W'(want.clocks_equal), READ_W'(out_clocks_equal));
        field_check("stored_before", READ_W'(want.stored_before), READ_W'(out_stored_before));
        field_check("stored_after", READ_W'(want.stored_after), READ_W'(out_stored_after));
      end
    end
  end

  // Watchdog: end the run when no word moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
        $display("Verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/vcu_pkg.sv
rtl/core/vcu_cnt_ram.sv
rtl/core/vcu_update.sv
rtl/core/vector_clock_unit_core.sv
bench/tb_top.sv
